FILE: src/avc_first_ue_golomb_decoder_unit_assert.svh
// Assertion helpers shared by the decoder modules.
// Each macro expects clk and rst_n to be visible in the module that uses it.
`ifndef AVC_FIRST_UE_GOLOMB_DECODER_UNIT_ASSERT_SVH
`define AVC_FIRST_UE_GOLOMB_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define AFUG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define AFUG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/afug_pkg.sv
`timescale 1ns / 1ps

package afug_pkg;

    localparam int MAX_PREFIX_DEFAULT = 31;

    // Decoding phase codes
    localparam logic [1:0] PH_PREFIX = 2'd0;
    localparam logic [1:0] PH_SUFFIX = 2'd1;
    localparam logic [1:0] PH_DONE   = 2'd2;

    typedef logic [1:0] status_t;

    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_TRUNCATED = 2'd1;
    localparam status_t ST_BAD_ESC   = 2'd2;
    localparam status_t ST_OVERFLOW  = 2'd3;

    localparam logic [7:0] ESC_BYTE   = 8'h03;
    localparam logic [7:0] ESC_MAX    = 8'h03;
    localparam logic [1:0] ZR_SAT     = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
    } item_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] code_value;
        status_t     status;
    } result_t;

    function automatic logic [3:0] leading_zeros8(input logic [7:0] b);
        logic [3:0] n;
        n = 4'd8;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
            begin
                n = 4'(7 - i);
            end
        end
        return n;
    endfunction

endpackage

FILE: src/afug_in_if.sv
`timescale 1ns / 1ps

interface afug_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;

    modport source (output valid, data_byte, first_byte, last_byte, input ready);
    modport sink   (input valid, data_byte, first_byte, last_byte, output ready);
endinterface

FILE: src/afug_out_if.sv
`timescale 1ns / 1ps

interface afug_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] code_value;
    logic [1:0]  status;

    modport source (output valid, code_value, status, input ready);
    modport sink   (input valid, code_value, status, output ready);
endinterface

FILE: src/afug_core.sv
`timescale 1ns / 1ps

`include "avc_first_ue_golomb_decoder_unit_assert.svh"

module afug_core #(
    parameter int MAX_PREFIX = afug_pkg::MAX_PREFIX_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             upd,
    input  afug_pkg::item_t  item,
    output afug_pkg::result_t res
);
    import afug_pkg::*;

    localparam int CW = $clog2(MAX_PREFIX + 1);
    localparam int AW = MAX_PREFIX + 1;
    localparam int SW = CW + 4;

    logic [1:0]    zr_reg,  zr_next;
    logic          esc_reg, esc_next;
    logic [1:0]    ph_reg,  ph_next;
    logic [CW-1:0] pc_reg,  pc_next;
    logic [CW-1:0] sl_reg,  sl_next;
    logic [AW-1:0] acc_reg, acc_next;

    // State as seen by this request: a first byte starts from a clean slate
    logic [1:0]    e_zr;
    logic          e_esc;
    logic [1:0]    e_ph;
    logic [CW-1:0] e_pc;
    logic [CW-1:0] e_sl;
    logic [AW-1:0] e_acc;

    logic          emit;
    status_t       status;
    logic [31:0]   value;
    logic          decode;
    logic          in_suf;
    logic [1:0]    zr_base;
    logic [3:0]    lz;
    logic [SW-1:0] sum;
    logic [3:0]    r;
    logic [7:0]    rem;
    logic [SW-1:0] sl_w;
    logic [AW-1:0] acc_w;
    logic [3:0]    k;
    logic [AW-1:0] acc_sh;
    logic [SW-1:0] sl_left;

    always_comb
    begin
        if (item.first_byte)
        begin
            e_zr  = 2'd0;
            e_esc = 1'b0;
            e_ph  = PH_PREFIX;
            e_pc  = '0;
            e_sl  = '0;
            e_acc = AW'(1);
        end
        else
        begin
            e_zr  = zr_reg;
            e_esc = esc_reg;
            e_ph  = ph_reg;
            e_pc  = pc_reg;
            e_sl  = sl_reg;
            e_acc = acc_reg;
        end
    end

    always_comb
    begin
        zr_next  = e_zr;
        esc_next = e_esc;
        ph_next  = e_ph;
        pc_next  = e_pc;
        sl_next  = e_sl;
        acc_next = e_acc;
        emit     = 1'b0;
        status   = ST_OK;
        value    = '0;
        decode   = 1'b0;
        in_suf   = 1'b0;
        zr_base  = e_esc ? 2'd0 : e_zr;
        lz       = leading_zeros8(item.data_byte);
        sum      = SW'(e_pc) + SW'(lz);
        r        = 4'd8;
        rem      = item.data_byte;
        sl_w     = SW'(e_sl);
        acc_w    = e_acc;
        k        = '0;
        acc_sh   = e_acc;
        sl_left  = SW'(e_sl);

        // Escape handling
        if (e_ph != PH_DONE)
        begin
            if (e_esc)
            begin
                esc_next = 1'b0;
                if (item.data_byte > ESC_MAX)
                begin
                    emit   = 1'b1;
                    status = ST_BAD_ESC;
                end
                else
                begin
                    decode = 1'b1;
                end
            end
            else if (e_zr == ZR_SAT && item.data_byte == ESC_BYTE)
            begin
                zr_next = 2'd0;
                if (item.last_byte)
                begin
                    emit   = 1'b1;
                    status = ST_BAD_ESC;
                end
                else
                begin
                    esc_next = 1'b1;
                end
            end
            else
            begin
                decode = 1'b1;
            end
        end

        if (decode)
        begin
            if (item.data_byte == 8'd0)
            begin
                zr_next = (zr_base == ZR_SAT) ? ZR_SAT : zr_base + 2'd1;
            end
            else
            begin
                zr_next = 2'd0;
            end

            if (e_ph == PH_PREFIX)
            begin
                if (sum > SW'(MAX_PREFIX))
                begin
                    emit   = 1'b1;
                    status = ST_OVERFLOW;
                end
                else if (item.data_byte == 8'd0)
                begin
                    pc_next = CW'(sum);
                end
                else if (sum == '0)
                begin
                    emit = 1'b1;
                end
                else
                begin
                    // leading one found: the bits below it start the suffix
                    in_suf = 1'b1;
                    sl_w   = sum;
                    acc_w  = AW'(1);
                    r      = 4'd7 - lz;
                    rem    = item.data_byte & 8'((9'd1 << r) - 9'd1);
                end
            end
            else
            begin
                in_suf = 1'b1;
            end

            if (in_suf)
            begin
                k        = (SW'(r) < sl_w) ? r : 4'(sl_w);
                acc_sh   = (acc_w << k) | AW'(rem >> (r - k));
                sl_left  = sl_w - SW'(k);
                acc_next = acc_sh;
                sl_next  = CW'(sl_left);
                if (sl_left == '0)
                begin
                    emit  = 1'b1;
                    value = 32'(acc_sh - AW'(1));
                end
                else
                begin
                    ph_next = PH_SUFFIX;
                end
            end

            if (!emit && item.last_byte)
            begin
                emit   = 1'b1;
                status = ST_TRUNCATED;
            end
        end

        if (emit)
        begin
            ph_next = PH_DONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zr_reg  <= 2'd0;
            esc_reg <= 1'b0;
            ph_reg  <= PH_PREFIX;
            pc_reg  <= '0;
            sl_reg  <= '0;
            acc_reg <= AW'(1);
        end
        else if (upd)
        begin
            zr_reg  <= zr_next;
            esc_reg <= esc_next;
            ph_reg  <= ph_next;
            pc_reg  <= pc_next;
            sl_reg  <= sl_next;
            acc_reg <= acc_next;
        end
    end

    assign res.valid      = upd && emit;
    assign res.code_value = value;
    assign res.status     = status;

    `AFUG_ASSERT_NOW(a_err_zero_value, res.valid && res.status != ST_OK, res.code_value == 32'd0, "error result carries a nonzero value")
    `AFUG_ASSERT_NEXT(a_done_after_result, res.valid, ph_reg == PH_DONE, "decoder not done after a result")
    `AFUG_ASSERT_NOW(a_suffix_count, ph_reg == PH_SUFFIX, sl_reg != '0, "suffix phase with no bits left")
    `AFUG_ASSERT_NOW(a_escape_clears_run, esc_reg, zr_reg == 2'd0, "zero run kept across a dropped escape")

endmodule

FILE: src/avc_first_ue_golomb_decoder_unit.sv
`timescale 1ns / 1ps
// An accepted byte is decoded from the input register into the result register.
// Throughput: one byte per cycle while the output is not stalled, set by the single decode pass.
// A waiting result stalls the input register only while the output side holds off.
// Reset (rst_n, async, active low) clears the handshake state and the decoder to a fresh payload.

`include "avc_first_ue_golomb_decoder_unit_assert.svh"

module avc_first_ue_golomb_decoder_unit #(
    parameter int MAX_PREFIX = afug_pkg::MAX_PREFIX_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    afug_in_if.sink           in_ch,
    afug_out_if.source        out_ch
);
    import afug_pkg::*;

    logic        s1_valid_reg;
    item_t       s1_item_reg;
    logic        advance;
    logic        upd;
    result_t     res;
    logic        out_valid_reg;
    logic [31:0] out_value_reg;
    status_t     out_status_reg;

    assign advance     = !(out_valid_reg && !out_ch.ready);
    assign upd         = s1_valid_reg && advance;
    assign in_ch.ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ch.valid && in_ch.ready)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            s1_item_reg.data_byte  <= in_ch.data_byte;
            s1_item_reg.first_byte <= in_ch.first_byte;
            s1_item_reg.last_byte  <= in_ch.last_byte;
        end
    end

    afug_core #(
        .MAX_PREFIX (MAX_PREFIX)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .upd   (upd),
        .item  (s1_item_reg),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            out_value_reg  <= res.code_value;
            out_status_reg <= res.status;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.code_value = out_value_reg;
    assign out_ch.status     = out_status_reg;

    `AFUG_ASSERT_NEXT(a_stall_holds_item, s1_valid_reg && !advance, s1_valid_reg, "stalled byte dropped")
    `AFUG_ASSERT_NOW(a_result_slot_free, res.valid, !out_valid_reg || out_ch.ready, "result overwrites a pending one")
    `AFUG_ASSERT_NEXT(a_result_loaded, res.valid, out_valid_reg, "result not presented")

endmodule

FILE: test/ue_result_checker.sv
`timescale 1ns / 1ps

module ue_result_checker #(
    parameter int MAX_PREFIX = afug_pkg::MAX_PREFIX_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  in_data_byte,
    input  logic        in_first_byte,
    input  logic        in_last_byte,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [31:0] out_code_value,
    input  logic [1:0]  out_status,
    output int          mismatches,
    output int          pending
);
    import afug_pkg::*;

    typedef struct {
        logic [31:0] code_value;
        status_t     status;
    } ue_result_t;

    ue_result_t ue_expected[$];

    // Decoder state as the block should hold it
    logic [1:0]  zero_run;
    logic        esc_pending;
    logic [1:0]  phase;
    logic [5:0]  prefix_count;
    logic [4:0]  suffix_left;
    logic [31:0] acc;

    task automatic report_mismatch(input string what);
        $display("%0t ns mismatch: %s", $time, what);
        mismatches++;
    endtask

    task automatic clear_decoder();
        zero_run     = 2'd0;
        esc_pending  = 1'b0;
        phase        = PH_PREFIX;
        prefix_count = 6'd0;
        suffix_left  = 5'd0;
        acc          = 32'd1;
    endtask

    // Work out the result, if any, that one payload byte causes.
    task automatic decode_ue_byte(input logic [7:0] b, input logic first, input logic last,
                                  output bit got, output ue_result_t res);
        logic bit_v;
        got            = 1'b0;
        res.code_value = 32'd0;
        res.status     = ST_OK;
        if (first)
        begin
            clear_decoder();
        end
        if (phase == PH_DONE)
        begin
            return;
        end
        if (esc_pending)
        begin
            esc_pending = 1'b0;
            if (b > ESC_MAX)
            begin
                got        = 1'b1;
                res.status = ST_BAD_ESC;
                phase      = PH_DONE;
                return;
            end
            zero_run = 2'd0;
        end
        else if (zero_run >= ZR_SAT && b == ESC_BYTE)
        begin
            // Drop the escape byte; a last escape has nothing behind it
            if (last)
            begin
                got        = 1'b1;
                res.status = ST_BAD_ESC;
                phase      = PH_DONE;
                return;
            end
            esc_pending = 1'b1;
            zero_run    = 2'd0;
            return;
        end
        if (b == 8'd0)
        begin
            zero_run = (zero_run >= ZR_SAT) ? ZR_SAT : zero_run + 2'd1;
        end
        else
        begin
            zero_run = 2'd0;
        end

        for (int i = 7; i >= 0; i--)
        begin
            bit_v = b[i];
            if (phase == PH_PREFIX)
            begin
                if (!bit_v)
                begin
                    if (int'(prefix_count) + 1 > MAX_PREFIX)
                    begin
                        got        = 1'b1;
                        res.status = ST_OVERFLOW;
                        phase      = PH_DONE;
                        return;
                    end
                    prefix_count++;
                    continue;
                end
                if (prefix_count == 6'd0)
                begin
                    got   = 1'b1;
                    phase = PH_DONE;
                    return;
                end
                phase       = PH_SUFFIX;
                suffix_left = prefix_count[4:0];
                acc         = 32'd1;
            end
            else
            begin
                acc         = {acc[30:0], bit_v};
                suffix_left = suffix_left - 5'd1;
                if (suffix_left == 5'd0)
                begin
                    got            = 1'b1;
                    res.code_value = acc - 32'd1;
                    phase          = PH_DONE;
                    return;
                end
            end
        end

        if (last)
        begin
            got        = 1'b1;
            res.status = ST_TRUNCATED;
            phase      = PH_DONE;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        ue_result_t want;
        ue_result_t next_res;
        bit         got;
        if (!rst_n)
        begin
            clear_decoder();
            ue_expected.delete();
            pending = 0;
        end
        else
        begin
            // A result leaves the block only after its request has passed the input and result registers
            if (out_valid && out_ready)
            begin
                if (ue_expected.size() == 0)
                begin
                    report_mismatch($sformatf("result value %0h status %0d with none expected",
                                              out_code_value, out_status));
                end
                else
                begin
                    want = ue_expected.pop_front();
                    if (out_code_value !== want.code_value)
                    begin
                        report_mismatch($sformatf("code_value %0h, expected %0h",
                                                  out_code_value, want.code_value));
                    end
                    if (out_status !== want.status)
                    begin
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  out_status, want.status));
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                decode_ue_byte(in_data_byte, in_first_byte, in_last_byte, got, next_res);
                if (got)
                begin
                    ue_expected.insert(ue_expected.size(), next_res);
                end
            end
            pending = ue_expected.size();
        end
    end
endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps

module tb;
    import afug_pkg::*;

    logic clk;
    logic rst_n;
    bit   calm;
    int   items_sent;
    int   mismatches;
    int   pending;

    afug_in_if  in_ch();
    afug_out_if out_ch();

    avc_first_ue_golomb_decoder_unit i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    ue_result_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_ch.valid),
        .in_ready       (in_ch.ready),
        .in_data_byte   (in_ch.data_byte),
        .in_first_byte  (in_ch.first_byte),
        .in_last_byte   (in_ch.last_byte),
        .out_valid      (out_ch.valid),
        .out_ready      (out_ch.ready),
        .out_code_value (out_ch.code_value),
        .out_status     (out_ch.status),
        .mismatches     (mismatches),
        .pending        (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    always @(posedge clk)
    begin
        out_ch.ready <= calm || ($urandom_range(0, 99) >= 37);
    end

    task automatic put_byte(input logic [7:0] b, input bit first, input bit last);
        while (!calm && $urandom_range(0, 99) < 37)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.data_byte  <= b;
        in_ch.first_byte <= first;
        in_ch.last_byte  <= last;
        @(posedge clk);
        while (!in_ch.ready)
        begin
            @(posedge clk);
        end
        items_sent++;
    endtask

    task automatic send_payload(input logic [7:0] pl[$], input bit mark_first,
                                input int last_idx);
        for (int i = 0; i < pl.size(); i++)
        begin
            put_byte(pl[i], mark_first && i == 0, i == last_idx);
        end
    endtask

    // Build one ue(v) code, padded to whole bytes and escaped as a slice payload.
    task automatic build_code(output logic [7:0] esc[$]);
        bit         bits[$];
        logic [7:0] b;
        int         p;
        int         r;
        int         zc;
        esc.delete();
        r = $urandom_range(0, 99);
        if (r < 65)
            p = $urandom_range(0, 7);
        else if (r < 85)
            p = $urandom_range(8, 20);
        else if (r < 95)
            p = $urandom_range(21, 31);
        else
            p = $urandom_range(32, 40);
        for (int i = 0; i < p; i++)
        begin
            bits.insert(bits.size(), 1'b0);
        end
        if (p <= MAX_PREFIX_DEFAULT)
        begin
            bits.insert(bits.size(), 1'b1);
            for (int i = 0; i < p; i++)
            begin
                bits.insert(bits.size(), 1'($urandom_range(0, 1)));
            end
        end
        while (bits.size() % 8 != 0)
        begin
            bits.insert(bits.size(), 1'($urandom_range(0, 1)));
        end
        r = $urandom_range(0, 2) * 8;
        for (int i = 0; i < r; i++)
        begin
            bits.insert(bits.size(), 1'($urandom_range(0, 1)));
        end
        zc = 0;
        for (int i = 0; i < bits.size() / 8; i++)
        begin
            b = 8'd0;
            for (int j = 0; j < 8; j++)
            begin
                b = {b[6:0], bits[8 * i + j]};
            end
            // Insert an escape wherever two zeros precede a small byte
            if (zc >= 2 && b <= ESC_MAX)
            begin
                esc.insert(esc.size(), ESC_BYTE);
                zc = 0;
            end
            esc.insert(esc.size(), b);
            zc = (b == 8'd0) ? zc + 1 : 0;
        end
    endtask

    initial
    begin
        logic [7:0] pl[$];
        int         r;
        int         k;
        int         last_idx;
        int         waited;
        bit         mark_first;
        items_sent        = 0;
        calm              <= 1'b0;
        rst_n             <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.data_byte   <= 8'd0;
        in_ch.first_byte  <= 1'b0;
        in_ch.last_byte   <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Bytes straight after reset decode as a fresh payload
        pl = {8'h80};
        send_payload(pl, 1'b0, 0);
        pl = {8'h40};
        send_payload(pl, 1'b1, 0);
        // Prefix overflow on the 32nd zero
        pl = {8'h00, 8'h00, 8'h00, 8'h00};
        send_payload(pl, 1'b1, 3);
        // Largest code: 31 zeros, a one, 31 ones
        pl = {8'h00, 8'h00, 8'h00, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFE};
        send_payload(pl, 1'b1, 7);
        pl = {8'h00};
        send_payload(pl, 1'b1, 0);
        // Escape marked last
        pl = {8'h00, 8'h00, 8'h03};
        send_payload(pl, 1'b1, 2);
        // Escaped byte out of range
        pl = {8'h00, 8'h00, 8'h03, 8'h04};
        send_payload(pl, 1'b1, 3);
        // Code ends mid byte; trailing escape is ignored, next first restarts
        pl = {8'h80, 8'h00, 8'h00, 8'h03};
        send_payload(pl, 1'b1, -1);

        while (items_sent < 1850)
        begin
            calm <= (items_sent >= 900 && items_sent < 1200);
            r = $urandom_range(0, 99);
            if (r < 75)
            begin
                build_code(pl);
                r = $urandom_range(0, 99);
                if (r < 8)
                begin
                    k = $urandom_range(0, pl.size());
                    pl.insert(k, 8'h00);
                    pl.insert(k + 1, 8'h00);
                    pl.insert(k + 2, ESC_BYTE);
                    pl.insert(k + 3, 8'($urandom_range(0, 255)));
                end
                else if (r < 15)
                begin
                    k = $urandom_range(0, pl.size() - 1);
                    pl[k] = pl[k] ^ (8'd1 << $urandom_range(0, 7));
                end
            end
            else
            begin
                pl.delete();
                k = $urandom_range(1, 6);
                for (int i = 0; i < k; i++)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 30)
                        pl.insert(pl.size(), 8'h00);
                    else if (r < 45)
                        pl.insert(pl.size(), ESC_BYTE);
                    else if (r < 60)
                        pl.insert(pl.size(), 8'($urandom_range(0, 3)));
                    else
                        pl.insert(pl.size(), 8'($urandom_range(0, 255)));
                end
            end
            r = $urandom_range(0, 99);
            if (r < 78)
                last_idx = pl.size() - 1;
            else if (r < 88)
                last_idx = $urandom_range(0, pl.size() - 1);
            else
                last_idx = -1;
            mark_first = ($urandom_range(0, 99) < 95);
            send_payload(pl, mark_first, last_idx);
        end
        in_ch.valid <= 1'b0;

        // Drain what is still in flight
        waited = 0;
        @(negedge clk);
        while (pending != 0 && waited < 5000)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (10) @(negedge clk);
        if (mismatches == 0 && pending == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            if (pending != 0)
            begin
                $display("%0d expected results never arrived", pending);
            end
            $display("FAILURE");
        end
        $finish;
    end
endmodule

FILE: files.f
+incdir+src
src/afug_pkg.sv
src/afug_in_if.sv
src/afug_out_if.sv
src/afug_core.sv
src/avc_first_ue_golomb_decoder_unit.sv
test/ue_result_checker.sv
test/tb.sv
